>>> design/rbds_pkg.sv
// rbds_pkg: shared types and constants of the 2x2 box downscaler
// payload structs, register indexes, configuration widths and reset values
// no dependencies
`default_nettype none

package rbds_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int ROW_LIMIT     = 4096;
	localparam int ROW_W         = 12;
	localparam int FW_W          = 11;
	localparam int FH_W          = 13;
	localparam int CFG_DW        = 13;
	localparam int CFG_IW        = 2;
	localparam int PIX_W         = 8;
	localparam int PSUM_W        = 9;
	localparam int LINE_W        = 3 * PSUM_W;

	localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
	} in_pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic             frame_last;
	} out_pix_t;

	// horizontal pair sums of an odd-row pixel pair that closes a block
	typedef struct packed {
		logic              emit;
		logic              last;
		logic [PSUM_W-1:0] sr;
		logic [PSUM_W-1:0] sg;
		logic [PSUM_W-1:0] sb;
	} pair_t;

endpackage

`default_nettype wire

>>> design/rgb_half_size_box_downscale_top.sv
// rgb_half_size_box_downscale_top: 2x2 box downscaler for RGB raster frames
//
// in_valid/in_ready/in_data take pixels in raster order, one item per cycle while in_ready is high.
// out_valid/out_ready/out_data give one item per 2x2 block: each channel is
// the block sum divided by four, rounded down; frame_last marks the last
// item of the frame. An odd last column or row produces no item.
// cfg_valid/cfg_ready/cfg_index/cfg_data write frame_width (index 0) and
// frame_height (index 1); cfg_ready is always high. Write only when idle.
// The item of a block passes the pending register, then the output register,
// after the pixel that closes it is accepted. Throughput: one pixel per cycle
// while in_ready is high, set by the single port line store, which takes one
// write or one read per pixel. A stalled receiver keeps the output register
// full; one more block can wait behind it, after which in_ready drops until
// the output is taken. Reset clears counters and the left pixel hold and
// restores 640x480; the line store is not cleared, each entry is written on
// an even row before the odd row reads it.
`default_nettype none

module rgb_half_size_box_downscale_top
	import rbds_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_pix_t           in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_pix_t               out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic              accept;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [LINE_W-1:0] mem_wdata;
	logic [LINE_W-1:0] mem_rdata;
	pair_t             pair;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	rbds_pair_ctl #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW(AW)
	) u_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.in_data(in_data),
		.mem_we(mem_we),
		.mem_re(mem_re),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.pair(pair)
	);

	rbds_line_mem #(
		.DEPTH(LINE_DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.re(mem_re),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	rbds_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair),
		.rd_data(mem_rdata),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

>>> design/rbds_line_mem.sv
// rbds_line_mem: line store of even-row pair sums, one entry per column pair
// single port synchronous memory, registered read data; uses rbds_pkg
`default_nettype none

module rbds_line_mem
	import rbds_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH / 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [AW-1:0]     addr,
	input  wire logic [LINE_W-1:0] wdata,
	output logic      [LINE_W-1:0] rdata
);

	logic [LINE_W-1:0] mem [DEPTH];
	logic [LINE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rdata = rd_data_q;

endmodule

`default_nettype wire

>>> design/rbds_pair_ctl.sv
// rbds_pair_ctl: configuration registers, raster counters, left pixel hold
// forms pair sums and issues line store writes and reads; uses rbds_pkg
`default_nettype none

module rbds_pair_ctl
	import rbds_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int AW        = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic              accept,
	input  wire in_pix_t           in_data,
	output logic                   mem_we,
	output logic                   mem_re,
	output logic      [AW-1:0]     mem_addr,
	output logic      [LINE_W-1:0] mem_wdata,
	output pair_t                  pair
);

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	in_pix_t          left_q;

	logic [WW-1:0]    w_eff;
	logic [FH_W-1:0]  h_eff;
	logic [WW-1:0]    col_p1;
	logic [FH_W-1:0]  row_p1;
	logic [WW-1:0]    last_pair;
	logic [FH_W-1:0]  last_row;
	logic             odd_col;
	logic             odd_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sizes into the supported range
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = FH_W'(1);
		end else if (32'(frame_height_q) > ROW_LIMIT) begin
			h_eff = FH_W'(ROW_LIMIT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	assign col_p1    = WW'(col_q) + WW'(1);
	assign row_p1    = FH_W'(row_q) + FH_W'(1);
	assign last_pair = WW'(w_eff >> 1) - WW'(1);
	// wraps to all ones for a one-row frame, so it never matches
	assign last_row  = {h_eff[FH_W-1:1], 1'b0} - FH_W'(1);
	assign odd_col   = col_q[0];
	assign odd_row   = row_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (!odd_col) begin
				left_q <= in_data;
			end
			if (col_p1 >= w_eff) begin
				col_q <= '0;
				if (row_p1 >= h_eff) begin
					row_q <= '0;
				end else begin
					row_q <= ROW_W'(row_p1);
				end
			end else begin
				col_q <= CW'(col_p1);
			end
		end
	end

	always_comb begin
		pair.sr   = {1'b0, left_q.red_in}   + {1'b0, in_data.red_in};
		pair.sg   = {1'b0, left_q.green_in} + {1'b0, in_data.green_in};
		pair.sb   = {1'b0, left_q.blue_in}  + {1'b0, in_data.blue_in};
		pair.emit = accept && odd_col && odd_row;
		pair.last = (WW'(col_q >> 1) == last_pair) && (FH_W'(row_q) == last_row);
	end

	assign mem_we    = accept && odd_col && !odd_row;
	assign mem_re    = accept && odd_col && odd_row;
	assign mem_addr  = AW'(col_q >> 1);
	assign mem_wdata = {pair.sr, pair.sg, pair.sb};

endmodule

`default_nettype wire

>>> design/rbds_out_stage.sv
// rbds_out_stage: adds stored and current pair sums, divides by four
// holds one pending block and one output register; uses rbds_pkg
`default_nettype none

module rbds_out_stage
	import rbds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pair_t             pair,
	input  wire logic [LINE_W-1:0] rd_data,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_pix_t               out_data
);

	pair_t             pair_s1;
	logic              valid_s1;
	logic              out_valid_q;
	out_pix_t          out_data_q;
	logic              adv_s1;
	logic [PSUM_W:0]   tr;
	logic [PSUM_W:0]   tg;
	logic [PSUM_W:0]   tb;

	assign adv_s1   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	assign tr = {1'b0, rd_data[3*PSUM_W-1:2*PSUM_W]} + {1'b0, pair_s1.sr};
	assign tg = {1'b0, rd_data[2*PSUM_W-1:PSUM_W]}   + {1'b0, pair_s1.sg};
	assign tb = {1'b0, rd_data[PSUM_W-1:0]}          + {1'b0, pair_s1.sb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pair.emit) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pair.emit) begin
			pair_s1 <= pair;
		end
		if (adv_s1 && valid_s1) begin
			out_data_q.red_out    <= tr[PSUM_W:2];
			out_data_q.green_out  <= tg[PSUM_W:2];
			out_data_q.blue_out   <= tb[PSUM_W:2];
			out_data_q.frame_last <= pair_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a blocked pending block must hold off new items
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !in_ready)
		else $error("input accepted while pending block is stalled");

	// the line store read data must stay put while its block waits
	a_rdata_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> $stable(rd_data))
		else $error("line store read data changed under a stalled block");

	// a closing pixel always leaves a pending block behind
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pair.emit |=> valid_s1)
		else $error("closing pixel lost");

	// a pending block that cannot advance stays pending
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("pending block dropped during stall");

endmodule

`default_nettype wire

>>> tb/sv/tb_rgb_half_size_box_downscale_top.sv
// tb_rgb_half_size_box_downscale_top: self-checking bench for the 2x2 box downscaler
// drives pixels, register writes and output stalls, and predicts every averaged block
// depends on rbds_pkg and rgb_half_size_box_downscale_top
`default_nettype none

module tb_rgb_half_size_box_downscale_top;
	import rbds_pkg::*;

	localparam int RANDOM_ITEMS  = 360;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LINE_DEPTH    = DEF_MAX_WIDTH / 2;
	// index with no register behind it
	localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

	// opening frame: row 0 at the reset width, then width 4, then height 4
	localparam in_pix_t OPENING [17] = '{
		24'hffffff, 24'hffffff, 24'h000000, 24'h0100ff,
		24'h123456,
		24'hffffff, 24'hffffff, 24'h010300, 24'h0100ff,
		24'h000000, 24'h000000, 24'h807ffe, 24'h7f8001,
		24'h000000, 24'h000000, 24'hff00aa, 24'h00ff55
	};

	class downscale_tracker;
		logic [LINE_W-1:0] pair_sums [LINE_DEPTH];
		in_pix_t           left_hold;
		int unsigned       col;
		int unsigned       row;
		logic [FW_W-1:0]   width_reg;
		logic [FH_W-1:0]   height_reg;
		out_pix_t          avg_due [$];
		int                errors;

		function new();
			foreach (pair_sums[i]) pair_sums[i] = '0;
			left_hold  = '0;
			col        = 0;
			row        = 0;
			width_reg  = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			errors     = 0;
		endfunction

		function void apply_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
			if (idx == REG_FRAME_WIDTH)
				width_reg = data[FW_W-1:0];
			else if (idx == REG_FRAME_HEIGHT)
				height_reg = data[FH_W-1:0];
		endfunction

		function bit at_origin();
			return col == 0 && row == 0;
		endfunction

		function void note_pixel(in_pix_t px);
			int unsigned w, h, slot, sr, sg, sb, tr, tg, tb;
			out_pix_t want;
			w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
			h = (height_reg == 0) ? 1 : (height_reg > ROW_LIMIT) ? ROW_LIMIT : height_reg;
			if (col % 2 == 0) begin
				left_hold = px;
			end else begin
				slot = (col / 2) % LINE_DEPTH;
				sr = int'(left_hold.red_in) + px.red_in;
				sg = int'(left_hold.green_in) + px.green_in;
				sb = int'(left_hold.blue_in) + px.blue_in;
				if (row % 2 == 0) begin
					pair_sums[slot] = {PSUM_W'(sr), PSUM_W'(sg), PSUM_W'(sb)};
				end else begin
					tr = pair_sums[slot][3*PSUM_W-1 -: PSUM_W] + sr;
					tg = pair_sums[slot][2*PSUM_W-1 -: PSUM_W] + sg;
					tb = pair_sums[slot][PSUM_W-1:0] + sb;
					want.red_out    = PIX_W'(tr >> 2);
					want.green_out  = PIX_W'(tg >> 2);
					want.blue_out   = PIX_W'(tb >> 2);
					// last pair of the last even-odd row pair
					want.frame_last = (col / 2 == w / 2 - 1) && (row == h / 2 * 2 - 1);
					avg_due.push_back(want);
				end
			end
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_block(out_pix_t got);
			out_pix_t want;
			if (avg_due.size() == 0) begin
				if (errors < 10)
					$display("unexpected item: r=%0d g=%0d b=%0d last=%0d",
						got.red_out, got.green_out, got.blue_out, got.frame_last);
				errors++;
			end else begin
				want = avg_due.pop_front();
				if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
						got.blue_out !== want.blue_out || got.frame_last !== want.frame_last) begin
					if (errors < 10)
						$display("mismatch: want r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
							want.red_out, want.green_out, want.blue_out, want.frame_last,
							got.red_out, got.green_out, got.blue_out, got.frame_last);
					errors++;
				end
			end
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	in_pix_t           in_data   = '0;
	logic              out_ready = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data  = '0;
	logic              in_ready;
	logic              out_valid;
	logic              cfg_ready;
	out_pix_t          out_data;

	int idle_pct = 29;
	int fed      = 0;
	int quiet    = 0;
	downscale_tracker tracker;

	rgb_half_size_box_downscale_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_block(out_data);
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [PIX_W-1:0] rand_level();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic send_pixel(in_pix_t px);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (!in_ready);
		tracker.note_pixel(px);
	endtask

	// one whole frame of random pixels, starting and ending at the origin
	task automatic feed_frame();
		do begin
			send_pixel({rand_level(), rand_level(), rand_level()});
			fed++;
		end while (!tracker.at_origin());
	endtask

	// wait for every block, then for the pipeline to empty of blockless pixels
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.avg_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits of a width write are junk the block must drop
	task automatic set_size(int unsigned w, int unsigned h);
		logic [CFG_DW-1:0] wdata;
		wdata = {2'($urandom_range(3)), FW_W'(w)};
		if ($urandom_range(1)) begin
			write_reg(REG_FRAME_WIDTH, wdata);
			write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
		end else begin
			write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
			write_reg(REG_FRAME_WIDTH, wdata);
		end
	endtask

	initial begin
		int unsigned w, h;
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shrink the width mid-row, the column counter then sits past the new edge
		for (int i = 0; i < 4; i++) send_pixel(OPENING[i]);
		settle();
		write_reg(REG_FRAME_WIDTH, 13'd4);
		for (int i = 4; i < 9; i++) send_pixel(OPENING[i]);
		settle();
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		for (int i = 9; i < 17; i++) send_pixel(OPENING[i]);
		settle();

		// zero sizes, single column, single row: no blocks at all
		set_size(0, 0);
		repeat (3) feed_frame();
		settle();
		set_size(1, 3);
		feed_frame();
		settle();
		set_size(5, 1);
		feed_frame();
		settle();
		write_reg(REG_SPARE, '1);

		// oversized width clamps to the longest line
		set_size(2047, 1);
		feed_frame();
		settle();

		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			idle_pct = (fed >= 100 && fed < 260) ? 0 : 29;
			case ($urandom_range(24))
				0: begin
					w = $urandom_range(17, 64);
					h = $urandom_range(0, 2);
				end
				1: begin
					w = $urandom_range(0, 3);
					h = $urandom_range(0, 9);
				end
				default: begin
					w = $urandom_range(1, 16);
					h = $urandom_range(1, 10);
				end
			endcase
			set_size(w, h);
			repeat ($urandom_range(1, 2)) feed_frame();
			settle();
		end

		if (tracker.errors == 0 && tracker.avg_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
